// File: hdl/hmac_toy_byte_hash_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the toy HMAC byte hash unit
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef HMAC_TOY_BYTE_HASH_UNIT_DEFINES_SVH
`define HMAC_TOY_BYTE_HASH_UNIT_DEFINES_SVH

// Same-cycle implication
`define HTBH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HTBH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/htbh_pkg.sv
// ---------------------------------------------------------------------------
// htbh_pkg
// Shared types, constants and the byte hash function of the toy HMAC unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htbh_pkg;

  // Fixed field and register widths
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned KEY_BLOCK_BYTES_DEF = 64;

  // Pad constants
  localparam logic [BYTE_W-1:0] INNER_PAD = 8'h36;
  localparam logic [BYTE_W-1:0] OUTER_PAD = 8'h5c;

  typedef logic [BYTE_W-1:0] byte_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for first item of a message
    S_INNER,  // inner pad pass
    S_HELD,   // hash the captured first item
    S_MID,    // mid-message, one byte per cycle
    S_OUTER,  // outer pad pass
    S_FINAL   // final hash into the output register
  } ctrl_state_e;

  // Datapath hash operations
  typedef enum logic [2:0] {
    HOP_NONE,
    HOP_PAD_IN,
    HOP_PAD_OUT,
    HOP_MSG_IN,
    HOP_MSG_HELD,
    HOP_FINAL
  } hop_e;

  typedef struct packed {
    logic start_inner;  // capture item, clear running hash
    hop_e op;
  } htbh_cmd_t;

  typedef struct packed {
    logic cnt_last;     // pad counter at final key byte
    logic held_last;    // captured item is the last one
    logic in_last;      // incoming item is the last one
    logic out_free;     // output register can take a tag
  } htbh_sts_t;

  // h = ((h + b) ^ (h << 1)) mod 256
  function automatic byte_t hash_byte(input byte_t h, input byte_t b);
    byte_t sum;
    byte_t dbl;
    sum = h + b;
    dbl = {h[BYTE_W-2:0], 1'b0};
    return sum ^ dbl;
  endfunction

endpackage

`default_nettype wire

// File: hdl/htbh_if.sv
// ---------------------------------------------------------------------------
// htbh_if
// Valid/ready channels for message items and result tags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface htbh_in_if
  import htbh_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t message_byte;
  logic  last_byte;
  logic  no_byte;

  modport source (output valid, output message_byte, output last_byte, output no_byte,
                  input ready);
  modport sink   (input valid, input message_byte, input last_byte, input no_byte,
                  output ready);
endinterface

interface htbh_out_if
  import htbh_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t tag;

  modport source (output valid, output tag, input ready);
  modport sink   (input valid, input tag, output ready);
endinterface

`default_nettype wire

// File: hdl/hmac_toy_byte_hash_unit.sv
// ---------------------------------------------------------------------------
// hmac_toy_byte_hash_unit
// Sequence: a first item is captured, then the inner pad pass runs and the
// captured item is hashed. Middle items: one per cycle. A last item is
// followed by the outer pad pass and the final hash before the tag sits in
// the output register.
// Reset: asynchronous active low; key words, hash and counters clear to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hmac_toy_byte_hash_unit_defines.svh"

module hmac_toy_byte_hash_unit
  import htbh_pkg::*;
#(
  parameter int unsigned KEY_BLOCK_BYTES = KEY_BLOCK_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  htbh_in_if.sink                    in_i,
  htbh_out_if.source                 out_o
);

  htbh_cmd_t cmd;
  htbh_sts_t sts;

  // Sequencer
  htbh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  htbh_dpath #(
    .KEY_BLOCK_BYTES (KEY_BLOCK_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (in_i.message_byte),
    .in_last_i   (in_i.last_byte),
    .in_none_i   (in_i.no_byte),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_tag_o   (out_o.tag),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // Every accepted transaction starts a pad pass or hashes its byte
  `HTBH_ASSERT_IMP(a_accept_cmd, in_i.valid && in_i.ready,
                   cmd.start_inner || (cmd.op == HOP_MSG_IN), "accept without command")
  // A tag is only loaded when the output register is free
  `HTBH_ASSERT_IMP(a_final_free, cmd.op == HOP_FINAL, sts.out_free, "tag overwrite")
  // A loaded tag is presented in the next cycle
  `HTBH_ASSERT_NXT(a_final_valid, cmd.op == HOP_FINAL, out_o.valid, "tag not presented")

endmodule

`default_nettype wire

// File: hdl/htbh_ctrl.sv
// ---------------------------------------------------------------------------
// htbh_ctrl
// Sequencer for pad passes, message bytes and tag output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htbh_ctrl
  import htbh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire htbh_sts_t sts_i,
  output htbh_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_INNER;
      S_INNER: if (sts_i.cnt_last) state_d = S_HELD;
      S_HELD:  state_d = sts_i.held_last ? S_OUTER : S_MID;
      S_MID:   if (in_valid_i && sts_i.in_last) state_d = S_OUTER;
      S_OUTER: if (sts_i.cnt_last) state_d = S_FINAL;
      S_FINAL: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.start_inner = 1'b0;
    cmd_o.op          = HOP_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.start_inner = in_valid_i;
      end
      S_INNER: cmd_o.op = HOP_PAD_IN;
      S_HELD:  cmd_o.op = HOP_MSG_HELD;
      S_MID: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = HOP_MSG_IN;
      end
      S_OUTER: cmd_o.op = HOP_PAD_OUT;
      S_FINAL: if (sts_i.out_free) cmd_o.op = HOP_FINAL;
      default: cmd_o.op = HOP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/htbh_dpath.sv
// ---------------------------------------------------------------------------
// htbh_dpath
// Key registers, pad counter, running hash and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htbh_dpath
  import htbh_pkg::*;
#(
  parameter int unsigned KEY_BLOCK_BYTES = KEY_BLOCK_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input payload
  input  wire byte_t                 in_byte_i,
  input  wire logic                  in_last_i,
  input  wire logic                  in_none_i,
  // output channel
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output byte_t                      out_tag_o,
  // control
  input  wire htbh_cmd_t             cmd_i,
  output htbh_sts_t                  sts_o
);

  localparam int unsigned KEY_WORDS = (KEY_BLOCK_BYTES + 7) / 8;
  localparam int unsigned WORD_W    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'((KEY_BLOCK_BYTES - 1) / 8);
  localparam logic [2:0]        LAST_BYTE = 3'((KEY_BLOCK_BYTES - 1) % 8);

  logic [CFG_DATA_W-1:0] key_q [KEY_WORDS];
  logic [WORD_W-1:0]     word_q, word_d;
  logic [2:0]            bsel_q, bsel_d;
  byte_t                 h_q, h_d;
  byte_t                 inner_q, inner_d;
  byte_t                 held_byte_q;
  logic                  held_last_q, held_none_q;
  byte_t                 tag_q, tag_d;
  logic                  out_valid_q, out_valid_d;

  logic [CFG_DATA_W-1:0] key_word;
  byte_t                 key_b;
  byte_t                 msg_b, msg_h;
  logic                  msg_last, msg_none;
  logic                  cnt_last;

  // Key byte at the pad counter
  assign key_word = key_q[word_q];
  assign key_b    = key_word[{bsel_q, 3'b000} +: BYTE_W];
  assign cnt_last = (word_q == LAST_WORD) && (bsel_q == LAST_BYTE);

  // Message byte source: live input or captured first item
  always_comb begin
    if (cmd_i.op == HOP_MSG_IN) begin
      msg_b    = in_byte_i;
      msg_last = in_last_i;
      msg_none = in_none_i;
    end else begin
      msg_b    = held_byte_q;
      msg_last = held_last_q;
      msg_none = held_none_q;
    end
    msg_h = msg_none ? h_q : hash_byte(h_q, msg_b);
  end

  // Hash and counter update
  always_comb begin
    h_d         = h_q;
    inner_d     = inner_q;
    word_d      = word_q;
    bsel_d      = bsel_q;
    tag_d       = tag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.start_inner) h_d = '0;
    case (cmd_i.op)
      HOP_PAD_IN, HOP_PAD_OUT: begin
        h_d = hash_byte(h_q, key_b ^ ((cmd_i.op == HOP_PAD_IN) ? INNER_PAD : OUTER_PAD));
        if (cnt_last) begin
          word_d = '0;
          bsel_d = '0;
        end else if (bsel_q == 3'd7) begin
          bsel_d = '0;
          word_d = word_q + 1'b1;
        end else begin
          bsel_d = bsel_q + 1'b1;
        end
      end
      HOP_MSG_IN, HOP_MSG_HELD: begin
        if (msg_last) begin
          inner_d = msg_h;
          h_d     = '0;
        end else begin
          h_d = msg_h;
        end
      end
      HOP_FINAL: begin
        tag_d       = hash_byte(h_q, inner_q);
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Key registers, writes beyond the key block are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_WORDS; i++) key_q[i] <= '0;
    end else if (cfg_we_i && (32'(cfg_idx_i) < KEY_WORDS)) begin
      key_q[cfg_idx_i[WORD_W-1:0]] <= cfg_data_i;
    end
  end

  // Control state and hash registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      bsel_q      <= '0;
      h_q         <= '0;
      inner_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      word_q      <= word_d;
      bsel_q      <= bsel_d;
      h_q         <= h_d;
      inner_q     <= inner_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    if (cmd_i.start_inner) begin
      held_byte_q <= in_byte_i;
      held_last_q <= in_last_i;
      held_none_q <= in_none_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_tag_o       = tag_q;
  assign sts_o.cnt_last  = cnt_last;
  assign sts_o.held_last = held_last_q;
  assign sts_o.in_last   = in_last_i;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire
